FILE: rtl/gllc_pkg.sv
// Package for the gamma lookup and luma converter: payload types, register codes, constants.
package gllc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned PROD_W   = SAMPLE_W + WEIGHT_W;
  // Three products plus the rounding half need two extra bits
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned FRAC_W   = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = WEIGHT_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_BYPASS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_INPUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_INPUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_GREEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BLUE   = 3'd5;

  // Register reset values (Rec. 709 weights in Q1.16)
  localparam logic                RST_LINEAR_BYPASS = 1'b1;
  localparam logic                RST_WIDE_INPUT    = 1'b0;
  localparam logic                RST_COLOR_INPUT   = 1'b1;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RED    = 17'd13933;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_GREEN  = 17'd46871;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_BLUE   = 17'd4732;

  // Item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // One half in Q.16 for round-to-nearest
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

  typedef struct packed {
    logic                operation;
    logic [SAMPLE_W-1:0] table_index;
    logic [SAMPLE_W-1:0] table_value;
    logic [SAMPLE_W-1:0] sample_blue;
    logic [SAMPLE_W-1:0] sample_green;
    logic [SAMPLE_W-1:0] sample_red;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] linear_red;
    logic [SAMPLE_W-1:0] linear_green;
    logic [SAMPLE_W-1:0] linear_blue;
    logic                luma_clipped;
  } out_item_t;

  // Per-lane control from the pipeline controller
  typedef struct packed {
    logic ld_s1;   // load lookup stage, issue table read
    logic ld_s2;   // load product stage
    logic tbl_we;  // table write item
    logic bypass;
    logic wide;
  } lane_ctrl_t;

endpackage

FILE: rtl/gllc_if.sv
// Valid/ready channel interfaces for input items and result items.
interface gllc_in_if;
  logic               valid;
  logic               ready;
  gllc_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface gllc_out_if;
  logic                valid;
  logic                ready;
  gllc_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/gllc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gllc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gllc_lane.sv
// One color lane: sample widening, tone table lookup, bypass select and weighting.
module gllc_lane #(
  parameter int unsigned TABLE_ADDR_BITS = 16
) (
  input  logic                                clk_i,
  input  gllc_pkg::lane_ctrl_t                ctrl_i,
  input  logic [TABLE_ADDR_BITS-1:0]          tbl_waddr_i,
  input  logic [gllc_pkg::SAMPLE_W-1:0]       tbl_wdata_i,
  input  logic [gllc_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic [gllc_pkg::WEIGHT_W-1:0]       weight_i,
  output logic [gllc_pkg::SAMPLE_W-1:0]       linear_o,
  output logic [gllc_pkg::PROD_W-1:0]         product_o
);

  localparam int unsigned Depth = 2 ** TABLE_ADDR_BITS;

  logic [gllc_pkg::SAMPLE_W-1:0] sample_wide;
  logic [TABLE_ADDR_BITS-1:0]    raddr;
  logic [gllc_pkg::SAMPLE_W-1:0] rdata;
  logic [gllc_pkg::SAMPLE_W-1:0] sample_q;
  logic [gllc_pkg::SAMPLE_W-1:0] linear;
  logic [gllc_pkg::SAMPLE_W-1:0] linear_q;
  logic [gllc_pkg::PROD_W-1:0]   product_q;

  // Narrow samples use their low byte, moved to the top
  assign sample_wide = ctrl_i.wide ? sample_i : {sample_i[7:0], 8'h00};
  assign raddr       = sample_wide[gllc_pkg::SAMPLE_W-1 -: TABLE_ADDR_BITS];

  // Private copy of the tone table; every lane sees every write
  gllc_ram #(
    .Width (gllc_pkg::SAMPLE_W),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.tbl_we),
    .waddr_i (tbl_waddr_i),
    .wdata_i (tbl_wdata_i),
    .re_i    (ctrl_i.ld_s1),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Lookup stage: keep the sample for bypass mode
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s1) begin
      sample_q <= sample_wide;
    end
  end

  assign linear = ctrl_i.bypass ? sample_q : rdata;

  // Product stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s2) begin
      linear_q  <= linear;
      product_q <= gllc_pkg::PROD_W'(weight_i) * gllc_pkg::PROD_W'(linear);
    end
  end

  assign linear_o  = linear_q;
  assign product_o = product_q;

endmodule

FILE: rtl/gllc_merge.sv
// Merge stage: sums the lane products, rounds, saturates and registers the result item.
module gllc_merge (
  input  logic                          clk_i,
  input  logic                          ld_i,
  input  logic                          color_i,
  input  logic [gllc_pkg::SAMPLE_W-1:0] lin_red_i,
  input  logic [gllc_pkg::SAMPLE_W-1:0] lin_green_i,
  input  logic [gllc_pkg::SAMPLE_W-1:0] lin_blue_i,
  input  logic [gllc_pkg::PROD_W-1:0]   prod_red_i,
  input  logic [gllc_pkg::PROD_W-1:0]   prod_green_i,
  input  logic [gllc_pkg::PROD_W-1:0]   prod_blue_i,
  output gllc_pkg::out_item_t           item_o
);

  localparam int unsigned IntW = gllc_pkg::SUM_W - gllc_pkg::FRAC_W;

  logic [gllc_pkg::SUM_W-1:0] sum;
  logic [IntW-1:0]            sum_int;
  logic                       over;
  gllc_pkg::out_item_t        item_d;
  gllc_pkg::out_item_t        item_q;

  // Weighted sum plus one half, then drop the fraction
  assign sum = gllc_pkg::ROUND_HALF
             + gllc_pkg::SUM_W'(prod_red_i)
             + gllc_pkg::SUM_W'(prod_green_i)
             + gllc_pkg::SUM_W'(prod_blue_i);
  assign sum_int = sum[gllc_pkg::SUM_W-1:gllc_pkg::FRAC_W];
  assign over    = |sum_int[IntW-1:gllc_pkg::SAMPLE_W];

  // Color mode forms luma; gray mode replicates the single channel
  always_comb begin
    if (color_i) begin
      item_d.luma         = over ? '1 : sum_int[gllc_pkg::SAMPLE_W-1:0];
      item_d.luma_clipped = over;
      item_d.linear_red   = lin_red_i;
      item_d.linear_green = lin_green_i;
      item_d.linear_blue  = lin_blue_i;
    end else begin
      item_d.luma         = lin_blue_i;
      item_d.luma_clipped = 1'b0;
      item_d.linear_red   = lin_blue_i;
      item_d.linear_green = lin_blue_i;
      item_d.linear_blue  = lin_blue_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: rtl/gamma_lut_luma_converter_core.sv
// Gamma lookup and luma converter: three RGB lanes, merge stage and pipeline control.
//
// Usage: input items arrive on in_if (valid/ready). A table write item
// (operation = write) stores table_value at the low TABLE_ADDR_BITS bits of
// table_index and gives no result. A pixel item gives one result item on
// out_if: linear R, G, B and luma with a saturation flag.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i while
// the block is idle; unknown indexes are ignored.
// Pipeline: a pixel accepted on in_if passes the table read at the accepting
// edge, the weighting register and the merge/output register to out_if.
// Throughput: one item per clock unless out_if stalls; the three lanes each own a
// copy of the tone table, so each lane does its lookup on its own read port.
// Reset: registers return to bypass, 8-bit, color and Rec. 709 weights. The
// tone table is not cleared; entries must be written before pixels read them.
// Stall: when out_if.ready is low the result holds in the output register and
// the stages behind it keep filling; in_if.ready drops only once all three
// stages hold items.
module gamma_lut_luma_converter_core #(
  parameter int unsigned TABLE_ADDR_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  gllc_in_if.sink                            in_if,
  gllc_out_if.source                         out_if,
  input  logic                               cfg_we_i,
  input  logic [gllc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gllc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic                          bypass_q, wide_q, color_q;
  logic [gllc_pkg::WEIGHT_W-1:0] w_red_q, w_green_q, w_blue_q;

  logic                 v1_q, v2_q, v3_q;
  logic                 v1_d, v2_d, v3_d;
  logic                 en1, en2, en3;
  logic                 in_acc;
  gllc_pkg::lane_ctrl_t lane_ctrl;

  logic [gllc_pkg::SAMPLE_W-1:0] lin_red, lin_green, lin_blue;
  logic [gllc_pkg::PROD_W-1:0]   prod_red, prod_green, prod_blue;
  logic [TABLE_ADDR_BITS-1:0]    tbl_waddr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q  <= gllc_pkg::RST_LINEAR_BYPASS;
      wide_q    <= gllc_pkg::RST_WIDE_INPUT;
      color_q   <= gllc_pkg::RST_COLOR_INPUT;
      w_red_q   <= gllc_pkg::RST_WEIGHT_RED;
      w_green_q <= gllc_pkg::RST_WEIGHT_GREEN;
      w_blue_q  <= gllc_pkg::RST_WEIGHT_BLUE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gllc_pkg::CFG_LINEAR_BYPASS: bypass_q  <= cfg_wdata_i[0];
        gllc_pkg::CFG_WIDE_INPUT:    wide_q    <= cfg_wdata_i[0];
        gllc_pkg::CFG_COLOR_INPUT:   color_q   <= cfg_wdata_i[0];
        gllc_pkg::CFG_WEIGHT_RED:    w_red_q   <= cfg_wdata_i;
        gllc_pkg::CFG_WEIGHT_GREEN:  w_green_q <= cfg_wdata_i;
        gllc_pkg::CFG_WEIGHT_BLUE:   w_blue_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when the next one moves
  assign en3 = !v3_q || out_if.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_if.ready = en1;
  assign in_acc      = in_if.valid && en1;

  assign v1_d = en1 ? (in_acc && (in_if.item.operation == gllc_pkg::OP_PIXEL)) : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Lane control
  always_comb begin
    lane_ctrl.ld_s1  = en1;
    lane_ctrl.ld_s2  = en2;
    lane_ctrl.tbl_we = in_acc && (in_if.item.operation == gllc_pkg::OP_WRITE);
    lane_ctrl.bypass = bypass_q;
    lane_ctrl.wide   = wide_q;
  end

  assign tbl_waddr = in_if.item.table_index[TABLE_ADDR_BITS-1:0];

  gllc_lane #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_lane_red (
    .clk_i       (clk_i),
    .ctrl_i      (lane_ctrl),
    .tbl_waddr_i (tbl_waddr),
    .tbl_wdata_i (in_if.item.table_value),
    .sample_i    (in_if.item.sample_red),
    .weight_i    (w_red_q),
    .linear_o    (lin_red),
    .product_o   (prod_red)
  );

  gllc_lane #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_lane_green (
    .clk_i       (clk_i),
    .ctrl_i      (lane_ctrl),
    .tbl_waddr_i (tbl_waddr),
    .tbl_wdata_i (in_if.item.table_value),
    .sample_i    (in_if.item.sample_green),
    .weight_i    (w_green_q),
    .linear_o    (lin_green),
    .product_o   (prod_green)
  );

  gllc_lane #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_lane_blue (
    .clk_i       (clk_i),
    .ctrl_i      (lane_ctrl),
    .tbl_waddr_i (tbl_waddr),
    .tbl_wdata_i (in_if.item.table_value),
    .sample_i    (in_if.item.sample_blue),
    .weight_i    (w_blue_q),
    .linear_o    (lin_blue),
    .product_o   (prod_blue)
  );

  gllc_merge u_merge (
    .clk_i        (clk_i),
    .ld_i         (en3),
    .color_i      (color_q),
    .lin_red_i    (lin_red),
    .lin_green_i  (lin_green),
    .lin_blue_i   (lin_blue),
    .prod_red_i   (prod_red),
    .prod_green_i (prod_green),
    .prod_blue_i  (prod_blue),
    .item_o       (out_if.item)
  );

  assign out_if.valid = v3_q;

`ifndef SYNTHESIS
  // Input back-pressure only when every stage holds an item
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with a free pipeline stage");

  // Table writes never create a result
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_if.item.operation == gllc_pkg::OP_WRITE)) |=> !v1_q)
    else $error("table write item entered the pixel pipeline");

  // Pixel items always enter the lookup stage
  a_pixel_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_if.item.operation == gllc_pkg::OP_PIXEL)) |=> v1_q)
    else $error("pixel item lost at the lookup stage");

  // Saturated luma is full scale
  a_clip_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.item.luma_clipped) |-> (out_if.item.luma == '1))
    else $error("clipped luma is not full scale");
`endif

endmodule

FILE: test/gamma_lut_luma_converter_core_test.sv
// Testbench for the gamma lookup and luma converter core: directed and random items, self-checking.
`timescale 1ns / 100ps

module gamma_lut_luma_converter_core_test;

  localparam int unsigned LUT_BITS   = 16;
  localparam int unsigned PIPE_DEPTH = 3;
  localparam int unsigned SETTLE     = 2 * PIPE_DEPTH + 2;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam int unsigned PHASES     = 12;
  localparam int unsigned PHASE_LEN  = 72;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic [gllc_pkg::WEIGHT_W-1:0] W_MAX = 17'h1FFFF;
  localparam logic [gllc_pkg::WEIGHT_W-1:0] W_ONE = 17'd65536;
  // Indexes past the last register; writes there must change nothing
  localparam logic [gllc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [gllc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // Mirror of the converter: tone table, registers and pending results
  class luma_scoreboard;
    logic [gllc_pkg::SAMPLE_W-1:0] tone_lut [0:(1 << LUT_BITS) - 1];
    bit                            loaded   [0:(1 << LUT_BITS) - 1];
    logic [LUT_BITS-1:0]           loaded_addrs [$];
    bit                            bypass;
    bit                            wide;
    bit                            color;
    logic [gllc_pkg::WEIGHT_W-1:0] w_red;
    logic [gllc_pkg::WEIGHT_W-1:0] w_green;
    logic [gllc_pkg::WEIGHT_W-1:0] w_blue;
    gllc_pkg::out_item_t           pending [$];
    int unsigned                   mismatches;

    function new();
      bypass     = gllc_pkg::RST_LINEAR_BYPASS;
      wide       = gllc_pkg::RST_WIDE_INPUT;
      color      = gllc_pkg::RST_COLOR_INPUT;
      w_red      = gllc_pkg::RST_WEIGHT_RED;
      w_green    = gllc_pkg::RST_WEIGHT_GREEN;
      w_blue     = gllc_pkg::RST_WEIGHT_BLUE;
      mismatches = 0;
    endfunction

    function void write_reg(logic [gllc_pkg::CFG_IDX_W-1:0] idx,
                            logic [gllc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gllc_pkg::CFG_LINEAR_BYPASS: bypass  = data[0];
        gllc_pkg::CFG_WIDE_INPUT:    wide    = data[0];
        gllc_pkg::CFG_COLOR_INPUT:   color   = data[0];
        gllc_pkg::CFG_WEIGHT_RED:    w_red   = data;
        gllc_pkg::CFG_WEIGHT_GREEN:  w_green = data;
        gllc_pkg::CFG_WEIGHT_BLUE:   w_blue  = data;
        default: ;
      endcase
    endfunction

    // Narrow samples keep their low byte, moved to the top
    function logic [gllc_pkg::SAMPLE_W-1:0] linearize(logic [gllc_pkg::SAMPLE_W-1:0] raw);
      logic [gllc_pkg::SAMPLE_W-1:0] s;
      s = wide ? raw : {raw[7:0], 8'h00};
      if (bypass) return s;
      return tone_lut[s[gllc_pkg::SAMPLE_W-1 -: LUT_BITS]];
    endfunction

    function void note_input(gllc_pkg::in_item_t it);
      gllc_pkg::out_item_t res;
      logic [63:0]         acc;
      logic [LUT_BITS-1:0] addr;
      if (it.operation == gllc_pkg::OP_WRITE) begin
        addr = it.table_index[LUT_BITS-1:0];
        tone_lut[addr] = it.table_value;
        if (!loaded[addr]) begin
          loaded[addr] = 1'b1;
          loaded_addrs = {loaded_addrs, addr};
        end
        return;
      end
      if (color) begin
        res.linear_blue  = linearize(it.sample_blue);
        res.linear_green = linearize(it.sample_green);
        res.linear_red   = linearize(it.sample_red);
        acc = 64'd32768;
        acc += 64'(w_blue) * 64'(res.linear_blue);
        acc += 64'(w_green) * 64'(res.linear_green);
        acc += 64'(w_red) * 64'(res.linear_red);
        acc = acc >> gllc_pkg::FRAC_W;
        if (acc > 64'd65535) begin
          res.luma         = 16'hFFFF;
          res.luma_clipped = 1'b1;
        end else begin
          res.luma         = acc[15:0];
          res.luma_clipped = 1'b0;
        end
      end else begin
        res.luma         = linearize(it.sample_blue);
        res.linear_red   = res.luma;
        res.linear_green = res.luma;
        res.linear_blue  = res.luma;
        res.luma_clipped = 1'b0;
      end
      pending = {pending, res};
    endfunction

    function void check_result(gllc_pkg::out_item_t got);
      gllc_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with none pending: luma=%h r=%h g=%h b=%h clip=%b",
                   $time, got.luma, got.linear_red, got.linear_green, got.linear_blue,
                   got.luma_clipped);
        return;
      end
      want = pending.pop_front();
      if (got.luma !== want.luma || got.linear_red !== want.linear_red ||
          got.linear_green !== want.linear_green || got.linear_blue !== want.linear_blue ||
          got.luma_clipped !== want.luma_clipped) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: want luma=%h r=%h g=%h b=%h clip=%b, got luma=%h r=%h g=%h b=%h clip=%b",
                   $time, want.luma, want.linear_red, want.linear_green, want.linear_blue,
                   want.luma_clipped, got.luma, got.linear_red, got.linear_green,
                   got.linear_blue, got.luma_clipped);
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [gllc_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [gllc_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  int unsigned                     send_idle_pct;
  int unsigned                     recv_stall_pct;
  int unsigned                     quiet_cycles;
  luma_scoreboard                  sb;

  gllc_in_if  pix_in ();
  gllc_out_if pix_out ();

  gamma_lut_luma_converter_core #(
    .TABLE_ADDR_BITS(LUT_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (pix_in),
    .out_if      (pix_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, check each accepted item
  always @(posedge clk_i) begin
    if (pix_out.valid && pix_out.ready) sb.check_result(pix_out.item);
    pix_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(gllc_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.item  <= it;
    do @(posedge clk_i); while (!pix_in.ready);
    sb.note_input(it);
  endtask

  // Stop sending, let every pending result drain and the pipe empty
  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(logic [gllc_pkg::CFG_IDX_W-1:0] idx,
                           logic [gllc_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Mode bits carry random upper bits, which the block must ignore
  task automatic configure(bit bp, bit wd, bit co, logic [gllc_pkg::WEIGHT_W-1:0] wr,
                           logic [gllc_pkg::WEIGHT_W-1:0] wg,
                           logic [gllc_pkg::WEIGHT_W-1:0] wb);
    wait_idle();
    write_reg(gllc_pkg::CFG_LINEAR_BYPASS, {16'($urandom), bp});
    write_reg(gllc_pkg::CFG_WIDE_INPUT, {16'($urandom), wd});
    write_reg(gllc_pkg::CFG_COLOR_INPUT, {16'($urandom), co});
    write_reg(gllc_pkg::CFG_WEIGHT_RED, wr);
    write_reg(gllc_pkg::CFG_WEIGHT_GREEN, wg);
    write_reg(gllc_pkg::CFG_WEIGHT_BLUE, wb);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_pacing(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  function automatic gllc_pkg::in_item_t pixel(logic [15:0] b, logic [15:0] g,
                                               logic [15:0] r);
    gllc_pkg::in_item_t it;
    it.operation    = gllc_pkg::OP_PIXEL;
    it.table_index  = 16'($urandom);
    it.table_value  = 16'($urandom);
    it.sample_blue  = b;
    it.sample_green = g;
    it.sample_red   = r;
    return it;
  endfunction

  function automatic gllc_pkg::in_item_t lut_write(logic [15:0] idx, logic [15:0] val);
    gllc_pkg::in_item_t it;
    it = pixel(16'($urandom), 16'($urandom), 16'($urandom));
    it.operation   = gllc_pkg::OP_WRITE;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic logic [15:0] edge_or_random();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // Samples that reach the table only address entries already written
  function automatic logic [15:0] pick_sample(bit reads_lut);
    logic [15:0] s;
    if (!reads_lut || sb.bypass) return edge_or_random();
    if (sb.wide) return 16'(sb.loaded_addrs[$urandom_range(0, sb.loaded_addrs.size() - 1)]);
    s = 16'($urandom);
    return s;
  endfunction

  function automatic gllc_pkg::in_item_t random_item();
    logic [15:0] idx;
    if ($urandom_range(0, 99) < (sb.bypass ? 15 : 30)) begin
      // Overwrites of live entries exercise read-after-write through the pipe
      if ($urandom_range(0, 1)) idx = 16'($urandom);
      else idx = 16'(sb.loaded_addrs[$urandom_range(0, sb.loaded_addrs.size() - 1)]);
      return lut_write(idx, edge_or_random());
    end
    return pixel(pick_sample(1'b1), pick_sample(sb.color), pick_sample(sb.color));
  endfunction

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    pix_in.valid   = 1'b0;
    pix_in.item    = '0;
    pix_out.ready  = 1'b0;
    quiet_cycles   = 0;
    set_pacing(0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers, bypass, narrow, color
    send_item(pixel(16'h0000, 16'h0000, 16'h0000));
    send_item(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(pixel(16'h00FF, 16'hFF00, 16'h1234));
    // Table writes land whatever the mode
    send_item(lut_write(16'hFFFF, 16'hFFFF));
    send_item(lut_write(16'h0000, 16'h0000));
    // Largest weights saturate the sum
    configure(1'b1, 1'b1, 1'b1, W_MAX, W_MAX, W_MAX);
    send_item(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(pixel(16'h0000, 16'h0000, 16'h0000));
    send_item(pixel(16'h0001, 16'h8000, 16'hFFFF));
    wait_idle();
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    cfg_we_i <= 1'b0;
    send_item(pixel(16'hFFFF, 16'h0000, 16'h0000));
    configure(1'b1, 1'b1, 1'b1, '0, '0, '0);
    send_item(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    // Gray: green and red ignored, no clip
    configure(1'b1, 1'b1, 1'b0, gllc_pkg::RST_WEIGHT_RED, gllc_pkg::RST_WEIGHT_GREEN,
              gllc_pkg::RST_WEIGHT_BLUE);
    send_item(pixel(16'hABCD, 16'h1111, 16'h2222));
    send_item(pixel(16'hFFFF, 16'h0000, 16'h0000));
    send_item(pixel(16'h0000, 16'hFFFF, 16'hFFFF));
    send_item(lut_write(16'hFF00, 16'hABCD));
    send_item(lut_write(16'h0000, 16'h1234));
    send_item(lut_write(16'h5A5A, 16'hFFFF));
    // Table lookups, narrow then wide
    configure(1'b0, 1'b0, 1'b1, W_ONE, W_ONE, W_ONE);
    send_item(pixel(16'h00FF, 16'hFF00, 16'h7700));
    send_item(pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
    configure(1'b0, 1'b1, 1'b0, gllc_pkg::RST_WEIGHT_RED, gllc_pkg::RST_WEIGHT_GREEN,
              gllc_pkg::RST_WEIGHT_BLUE);
    send_item(pixel(16'h5A5A, 16'($urandom), 16'($urandom)));
    send_item(pixel(16'hFFFF, 16'($urandom), 16'($urandom)));
    send_item(pixel(16'h0000, 16'($urandom), 16'($urandom)));
    configure(1'b0, 1'b1, 1'b1, gllc_pkg::RST_WEIGHT_RED, gllc_pkg::RST_WEIGHT_GREEN,
              gllc_pkg::RST_WEIGHT_BLUE);
    send_item(pixel(16'hFFFF, 16'h0000, 16'h5A5A));
    send_item(lut_write(16'h5A5A, 16'h0000));
    send_item(pixel(16'h5A5A, 16'h5A5A, 16'h5A5A));

    // Fill every entry a narrow sample can address
    for (int a = 0; a < 256; a++) send_item(lut_write(16'(a << 8), edge_or_random()));

    // Random phases over several register settings and pacing modes
    for (int k = 0; k < PHASES; k++) begin
      set_pacing(k % 4);
      case (k)
        0: configure(1'b1, 1'b0, 1'b1, gllc_pkg::RST_WEIGHT_RED,
                     gllc_pkg::RST_WEIGHT_GREEN, gllc_pkg::RST_WEIGHT_BLUE);
        1: configure(1'b1, 1'b1, 1'b1, W_MAX, W_MAX, W_MAX);
        2: configure(1'b0, 1'b0, 1'b1, gllc_pkg::RST_WEIGHT_RED,
                     gllc_pkg::RST_WEIGHT_GREEN, gllc_pkg::RST_WEIGHT_BLUE);
        3: configure(1'b0, 1'b1, 1'b1, 17'($urandom), 17'($urandom), 17'($urandom));
        4: configure(1'b0, 1'b1, 1'b0, gllc_pkg::RST_WEIGHT_RED,
                     gllc_pkg::RST_WEIGHT_GREEN, gllc_pkg::RST_WEIGHT_BLUE);
        5: configure(1'b1, 1'b1, 1'b0, 17'($urandom), 17'($urandom), 17'($urandom));
        6: configure(1'b0, 1'b0, 1'b0, gllc_pkg::RST_WEIGHT_RED,
                     gllc_pkg::RST_WEIGHT_GREEN, gllc_pkg::RST_WEIGHT_BLUE);
        7: configure(1'b1, 1'b0, 1'b1, '0, '0, '0);
        8: configure(1'b0, 1'b1, 1'b1, W_ONE, '0, '0);
        11: configure(1'b1, 1'b1, 1'b1, W_ONE, W_ONE, W_ONE);
        default: configure(1'($urandom), 1'($urandom), 1'($urandom),
                           17'($urandom), 17'($urandom), 17'($urandom));
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Now and then the sender holds off until the pipe has drained
        if (k % 3 == 0 && n == PHASE_LEN / 2) wait_idle();
        send_item(random_item());
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gllc_pkg.sv
rtl/gllc_if.sv
rtl/gllc_ram.sv
rtl/gllc_lane.sv
rtl/gllc_merge.sv
rtl/gamma_lut_luma_converter_core.sv
test/gamma_lut_luma_converter_core_test.sv
